// File: rtl/bpf_pkg.sv
// bpf_pkg: opcodes, default widths and curve weight tables for the path flattener
// no dependencies; imported by bezier_path_flattener_top
package bpf_pkg;

  typedef enum logic [2:0] {
    OpMove  = 3'b000,
    OpLine  = 3'b001,
    OpQuad  = 3'b010,
    OpCubic = 3'b011,
    OpClose = 3'b100
  } opcode_e;

  localparam int unsigned CoordBitsDef = 24;

  // all curves are evaluated over a denominator of 64
  localparam int unsigned RoundShift  = 6;
  localparam int unsigned RoundHalf   = 32;
  localparam int unsigned WeightBits  = 7;
  localparam int unsigned GuardBits   = 8;

  typedef logic [WeightBits-1:0] weight_t;

  // [cubic][step][term], terms are start, p1, p2, p3
  // quadratic weights are the /16 weights scaled by four
  localparam weight_t CurveWeight [2][4][4] = '{
    '{ '{7'd36, 7'd24, 7'd4,  7'd0 },
       '{7'd16, 7'd32, 7'd16, 7'd0 },
       '{7'd4,  7'd24, 7'd36, 7'd0 },
       '{7'd0,  7'd0,  7'd64, 7'd0 } },
    '{ '{7'd27, 7'd27, 7'd9,  7'd1 },
       '{7'd8,  7'd24, 7'd24, 7'd8 },
       '{7'd1,  7'd9,  7'd27, 7'd27},
       '{7'd0,  7'd0,  7'd0,  7'd64} }
  };

endpackage

// File: rtl/bezier_path_flattener_top.sv
// bezier_path_flattener_top: flattens move, line, quadratic and cubic path elements
// into vertices, four per curve; depends on bpf_pkg
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-------------------------------------
//   in      | input     | in_valid_i / in_ready_o | opcode, first_of_path, p1..p3 x/y
//   out     | output    | out_valid_o/out_ready_i | point_x, point_y, last_of_run
//
// a move or line yields one vertex and a curve four: the vertex stage emits one vertex
// per cycle into the output register while the output does not stall; close, unknown
// opcodes and curves with no current point are accepted and emit nothing
// the next item is accepted in the cycle the current item's last vertex moves out
// reset clears the current point and all valid flags; stalls on the output hold the
// vertex stage and, through it, the input
module bezier_path_flattener_top
  import bpf_pkg::*;
#(
  parameter int unsigned COORD_BITS = CoordBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,

  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [2:0]                   opcode_i,
  input  logic                         first_of_path_i,
  input  logic signed [COORD_BITS-1:0] p1_x_i,
  input  logic signed [COORD_BITS-1:0] p1_y_i,
  input  logic signed [COORD_BITS-1:0] p2_x_i,
  input  logic signed [COORD_BITS-1:0] p2_y_i,
  input  logic signed [COORD_BITS-1:0] p3_x_i,
  input  logic signed [COORD_BITS-1:0] p3_y_i,

  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [COORD_BITS-1:0] point_x_o,
  output logic signed [COORD_BITS-1:0] point_y_o,
  output logic                         last_of_run_o
);

  localparam int unsigned SumBits = COORD_BITS + GuardBits;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [SumBits-1:0]    sum_t;

  // current point of the path
  coord_t prev_x_q, prev_y_q;
  coord_t prev_x_d, prev_y_d;
  logic   have_point_q, have_point_d;

  // vertex stage: the element being flattened
  logic       work_valid_q;
  logic       work_curve_q;
  logic       work_cubic_q;
  logic [1:0] step_q;
  coord_t     pt_x_q [4];   // start point, p1, p2, p3
  coord_t     pt_y_q [4];

  // output register
  logic   out_valid_q;
  coord_t out_x_q, out_y_q;
  logic   out_last_q;

  logic   work_last, advance, accept;
  logic   have_eff, is_point, is_curve, emits;
  coord_t start_x, start_y, end_x, end_y;
  coord_t vert_x, vert_y;
  coord_t cand_x [2][4];
  coord_t cand_y [2][4];

  function automatic sum_t wterm(coord_t v, weight_t w);
    sum_t ws;
    ws = sum_t'({1'b0, w});
    return sum_t'(v) * ws;
  endfunction

  // handshake
  assign work_last  = !work_curve_q || (step_q == 2'd3);
  assign advance    = work_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !work_valid_q || (advance && work_last);
  assign accept     = in_valid_i && in_ready_o;

  // element decode, with the start-of-path clear applied first
  assign have_eff = have_point_q && !first_of_path_i;
  assign start_x  = first_of_path_i ? '0 : prev_x_q;
  assign start_y  = first_of_path_i ? '0 : prev_y_q;
  assign is_point = (opcode_i == OpMove) || (opcode_i == OpLine);
  assign is_curve = ((opcode_i == OpQuad) || (opcode_i == OpCubic)) && have_eff;
  assign emits    = is_point || is_curve;

  // the last vertex of any element is its end point exactly
  always_comb begin
    end_x = p1_x_i;
    end_y = p1_y_i;
    if (opcode_i == OpQuad) begin
      end_x = p2_x_i;
      end_y = p2_y_i;
    end else if (opcode_i == OpCubic) begin
      end_x = p3_x_i;
      end_y = p3_y_i;
    end
  end

  always_comb begin
    prev_x_d     = prev_x_q;
    prev_y_d     = prev_y_q;
    have_point_d = have_point_q;
    if (accept) begin
      if (emits) begin
        prev_x_d     = end_x;
        prev_y_d     = end_y;
        have_point_d = 1'b1;
      end else if (first_of_path_i) begin
        prev_x_d     = '0;
        prev_y_d     = '0;
        have_point_d = 1'b0;
      end
    end
  end

  // one candidate vertex per curve kind and step, constant weights each
  for (genvar c = 0; c < 2; c++) begin : g_kind
    for (genvar s = 0; s < 4; s++) begin : g_step
      sum_t sum_x, sum_y, rnd_x, rnd_y, shf_x, shf_y;
      always_comb begin
        sum_x = wterm(pt_x_q[0], CurveWeight[c][s][0]) + wterm(pt_x_q[1], CurveWeight[c][s][1])
              + wterm(pt_x_q[2], CurveWeight[c][s][2]) + wterm(pt_x_q[3], CurveWeight[c][s][3]);
        sum_y = wterm(pt_y_q[0], CurveWeight[c][s][0]) + wterm(pt_y_q[1], CurveWeight[c][s][1])
              + wterm(pt_y_q[2], CurveWeight[c][s][2]) + wterm(pt_y_q[3], CurveWeight[c][s][3]);
        // round half up, then floor shift
        rnd_x = sum_x + sum_t'(RoundHalf);
        rnd_y = sum_y + sum_t'(RoundHalf);
        shf_x = rnd_x >>> RoundShift;
        shf_y = rnd_y >>> RoundShift;
        cand_x[c][s] = shf_x[COORD_BITS-1:0];
        cand_y[c][s] = shf_y[COORD_BITS-1:0];
      end
    end
  end

  // a move or line passes its point straight through
  assign vert_x = work_curve_q ? cand_x[work_cubic_q][step_q] : pt_x_q[1];
  assign vert_y = work_curve_q ? cand_y[work_cubic_q][step_q] : pt_y_q[1];

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q     <= '0;
      prev_y_q     <= '0;
      have_point_q <= 1'b0;
      work_valid_q <= 1'b0;
      step_q       <= 2'd0;
      out_valid_q  <= 1'b0;
    end else begin
      prev_x_q     <= prev_x_d;
      prev_y_q     <= prev_y_d;
      have_point_q <= have_point_d;

      if (advance) begin
        step_q <= step_q + 2'd1;
        if (work_last) begin
          work_valid_q <= 1'b0;
        end
      end
      if (accept && emits) begin
        work_valid_q <= 1'b1;
        step_q       <= 2'd0;
      end

      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept && emits) begin
      work_curve_q <= is_curve;
      work_cubic_q <= (opcode_i == OpCubic);
      pt_x_q[0]    <= start_x;
      pt_y_q[0]    <= start_y;
      pt_x_q[1]    <= p1_x_i;
      pt_y_q[1]    <= p1_y_i;
      pt_x_q[2]    <= p2_x_i;
      pt_y_q[2]    <= p2_y_i;
      pt_x_q[3]    <= p3_x_i;
      pt_y_q[3]    <= p3_y_i;
    end
    if (advance) begin
      out_x_q    <= vert_x;
      out_y_q    <= vert_y;
      out_last_q <= work_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign point_x_o     = out_x_q;
  assign point_y_o     = out_y_q;
  assign last_of_run_o = out_last_q;

endmodule
